FILE: sv/assert_macros.svh
// Assertion macros used by the framebuffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: sv/rgbfb_pkg.sv
// Constants and types of the RGB565 framebuffer.
`default_nettype none

package rgbfb_pkg;

  localparam int DISPLAY_WIDTH  = 480;
  localparam int DISPLAY_HEIGHT = 320;

  localparam int FB_WORDS = DISPLAY_WIDTH * DISPLAY_HEIGHT / 2;
  localparam int MEM_AW   = $clog2(FB_WORDS);

  localparam int ADDR_W  = 20;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = ADDR_W - 2;
  localparam int P_W     = IDX_W + 1;
  localparam int RECIP   = (1 << P_W) / DISPLAY_WIDTH;
  localparam int W_W     = $clog2(DISPLAY_WIDTH + 1);
  localparam int X_W     = $clog2(DISPLAY_WIDTH);
  localparam int COORD_W = 9;
  localparam int CH_W    = 8;

  typedef enum logic [1:0] {
    KIND_READ      = 2'd0,
    KIND_PIXEL     = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_OUT_RANGE = 2'd3
  } kind_t;

endpackage

`default_nettype wire

FILE: sv/rgb565_framebuffer_with_pixel_updates_top.sv
// RGB565 framebuffer with read/write access and pixel update reporting.
//
// Command channel: an access is taken on a rising edge with start high and
// busy low; mode selects read (0) or write (1), address is a byte offset
// (low two bits ignored), write_data holds two pixels, first in the top half.
// Result channel: each result shows for one cycle with strobe high; the
// receiver cannot stall it. last marks the final result of an access.
// A read gives one result, registered in the LOOK state; busy drops with it,
// so the next access can be taken while the result shows.
// A write that is out of range or leaves the word unchanged gives one result
// likewise. A write that changes the word stores it in LOOK and gives two
// pixel updates from PIX0 and PIX1 and a write-done result from DONE, with
// busy high until the done result. These states follow the read-compare-write
// of the frame memory and the two-step coordinate divide.
// After reset the frame memory is cleared one word a cycle, all 76800 words
// of a 480x320 display, with busy held high.
`default_nettype none

`include "assert_macros.svh"

module rgb565_framebuffer_with_pixel_updates_top
  import rgbfb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 mode,
  input  wire logic [ADDR_W-1:0]    address,
  input  wire logic [DATA_W-1:0]    write_data,
  output logic                      strobe,
  output logic [1:0]                kind,
  output logic [DATA_W-1:0]         read_data,
  output logic [COORD_W-1:0]        pixel_x,
  output logic [COORD_W-1:0]        pixel_y,
  output logic [CH_W-1:0]           red,
  output logic [CH_W-1:0]           green,
  output logic [CH_W-1:0]           blue,
  output logic                      changed,
  output logic                      last
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_PIX0,
    ST_PIX1,
    ST_DONE
  } state_t;

  localparam logic [P_W-1:0]    RECIP_C  = P_W'(RECIP);
  localparam logic [W_W-1:0]    WIDTH_C  = W_W'(DISPLAY_WIDTH);
  localparam logic [P_W-1:0]    WIDTH_P  = P_W'(DISPLAY_WIDTH);
  localparam logic [X_W:0]      WIDTH_X  = (X_W+1)'(DISPLAY_WIDTH);
  localparam logic [31:0]       WORDS_C  = 32'(FB_WORDS);
  localparam logic [MEM_AW-1:0] LAST_WA  = MEM_AW'(FB_WORDS - 1);

  state_t              state;
  logic [MEM_AW-1:0]   clr_addr;
  logic                req_mode;
  logic [IDX_W-1:0]    req_idx;
  logic [DATA_W-1:0]   req_data;
  logic                req_in_range;
  logic [P_W-1:0]      q_est;
  logic [P_W-1:0]      rem_raw;
  logic [X_W-1:0]      x0;
  logic [P_W-1:0]      y0;
  logic [DATA_W-1:0]   rd_word;

  logic [DATA_W-1:0]   frame_words [FB_WORDS];

  logic                accept;
  logic [IDX_W-1:0]    in_idx;
  logic [P_W-1:0]      in_p;
  logic [2*P_W-1:0]    prod_q;
  logic [P_W+W_W-1:0]  prod_w;
  logic [P_W-1:0]      rem_next;
  logic                rem_ge;
  logic [X_W-1:0]      x0_c;
  logic [P_W-1:0]      y0_c;
  logic [X_W:0]        x1_sum;
  logic                wrap;
  logic [X_W-1:0]      x1_c;
  logic [P_W-1:0]      y1_c;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_wa;
  logic [DATA_W-1:0]   mem_wd;
  logic                word_diff;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign in_idx = address[ADDR_W-1:2];
  assign in_p   = {in_idx, 1'b0};
  assign prod_q = (2*P_W)'(in_p) * (2*P_W)'(RECIP_C);
  assign prod_w = (P_W+W_W)'(q_est) * (P_W+W_W)'(WIDTH_C);
  assign rem_next = {req_idx, 1'b0} - prod_w[P_W-1:0];

  // quotient estimate is exact or one low
  assign rem_ge = (rem_raw >= WIDTH_P);
  assign x0_c   = rem_ge ? X_W'(rem_raw - WIDTH_P) : X_W'(rem_raw);
  assign y0_c   = rem_ge ? q_est + P_W'(1) : q_est;

  assign x1_sum = {1'b0, x0} + (X_W+1)'(1);
  assign wrap   = (x1_sum >= WIDTH_X);
  assign x1_c   = wrap ? '0 : x1_sum[X_W-1:0];
  assign y1_c   = wrap ? y0 + P_W'(1) : y0;

  assign word_diff = (rd_word != req_data);
  assign mem_we = (state == ST_CLEAR) ||
                  ((state == ST_LOOK) && req_mode && req_in_range && word_diff);
  assign mem_wa = (state == ST_CLEAR) ? clr_addr : MEM_AW'(req_idx);
  assign mem_wd = (state == ST_CLEAR) ? '0 : req_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_words[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_word <= frame_words[MEM_AW'(in_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + MEM_AW'(1);
          if (clr_addr == LAST_WA) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_mode     <= mode;
            req_idx      <= in_idx;
            req_data     <= write_data;
            req_in_range <= (32'(in_idx) < WORDS_C);
            q_est        <= prod_q[2*P_W-1:P_W];
            state        <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          rem_raw   <= rem_next;
          strobe    <= 1'b1;
          read_data <= '0;
          pixel_x   <= '0;
          pixel_y   <= '0;
          red       <= '0;
          green     <= '0;
          blue      <= '0;
          changed   <= 1'b0;
          last      <= 1'b1;
          state     <= ST_IDLE;
          if (!req_mode) begin
            kind      <= KIND_READ;
            read_data <= req_in_range ? rd_word : '0;
          end else if (!req_in_range) begin
            kind <= KIND_OUT_RANGE;
          end else if (!word_diff) begin
            kind <= KIND_DONE;
          end else begin
            strobe <= 1'b0;
            state  <= ST_PIX0;
          end
        end
        ST_PIX0: begin
          x0      <= x0_c;
          y0      <= y0_c;
          strobe  <= 1'b1;
          kind    <= KIND_PIXEL;
          pixel_x <= COORD_W'(x0_c);
          pixel_y <= COORD_W'(y0_c);
          red     <= {req_data[31:27], 3'b000};
          green   <= {req_data[26:21], 2'b00};
          blue    <= {req_data[20:16], 3'b000};
          last    <= 1'b0;
          state   <= ST_PIX1;
        end
        ST_PIX1: begin
          strobe  <= 1'b1;
          kind    <= KIND_PIXEL;
          pixel_x <= COORD_W'(x1_c);
          pixel_y <= COORD_W'(y1_c);
          red     <= {req_data[15:11], 3'b000};
          green   <= {req_data[10:5], 2'b00};
          blue    <= {req_data[4:0], 3'b000};
          last    <= 1'b0;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          strobe  <= 1'b1;
          kind    <= KIND_DONE;
          pixel_x <= '0;
          pixel_y <= '0;
          red     <= '0;
          green   <= '0;
          blue    <= '0;
          changed <= 1'b1;
          last    <= 1'b1;
          state   <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NXT(a_no_result_after_accept, clk, rst, accept, !strobe)
  `ASSERT_IMP(a_done_follows_pixel, clk, rst, strobe && (kind == KIND_DONE) && changed, $past(strobe) && ($past(kind) == KIND_PIXEL))
  `ASSERT_IMP(a_single_results_last, clk, rst, strobe && (kind != KIND_PIXEL), last)

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Testbench for the RGB565 framebuffer: directed and random accesses checked against a predictor.
`timescale 1ns / 1ps

module testbench
  import rgbfb_pkg::*;
();

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam int   IDLE_LIMIT = 300000;

  typedef struct {
    kind_t               kind;
    logic [DATA_W-1:0]   read_data;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [CH_W-1:0]     red;
    logic [CH_W-1:0]     green;
    logic [CH_W-1:0]     blue;
    logic                changed;
    logic                last;
  } fb_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic                mode;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   write_data;
  logic                strobe;
  logic [1:0]          kind;
  logic [DATA_W-1:0]   read_data;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic [CH_W-1:0]     red;
  logic [CH_W-1:0]     green;
  logic [CH_W-1:0]     blue;
  logic                changed;
  logic                last;

  logic [DATA_W-1:0]   fb_image [int unsigned];
  fb_result_t          pending_results [$];
  int                  mismatches = 0;
  int                  gap_pct = 0;
  int                  quiet_cycles = 0;

  rgb565_framebuffer_with_pixel_updates_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .strobe     (strobe),
    .kind       (kind),
    .read_data  (read_data),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .changed    (changed),
    .last       (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic fb_result_t blank_result(kind_t k);
    fb_result_t r;
    r.kind = k;
    r.read_data = '0;
    r.px = '0;
    r.py = '0;
    r.red = '0;
    r.green = '0;
    r.blue = '0;
    r.changed = 1'b0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic fb_result_t pixel_result(logic [15:0] pix, int unsigned x, int unsigned y);
    fb_result_t r;
    r = blank_result(KIND_PIXEL);
    r.px = x[COORD_W-1:0];
    r.py = y[COORD_W-1:0];
    r.red = {pix[15:11], 3'b000};
    r.green = {pix[10:5], 2'b00};
    r.blue = {pix[4:0], 3'b000};
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] stored_word(int unsigned idx);
    return fb_image.exists(idx) ? fb_image[idx] : '0;
  endfunction

  // Expected results of one access, in order of arrival.
  task automatic predict_access(logic m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    int unsigned idx, p, x0, y0, x1, y1;
    logic [DATA_W-1:0] cur;
    fb_result_t r;
    idx = 32'(a) >> 2;
    cur = stored_word(idx);
    if (m == MODE_READ) begin
      r = blank_result(KIND_READ);
      r.read_data = (idx < FB_WORDS) ? cur : '0;
      pending_results.push_back(r);
    end else if (idx >= FB_WORDS) begin
      pending_results.push_back(blank_result(KIND_OUT_RANGE));
    end else if (cur == d) begin
      pending_results.push_back(blank_result(KIND_DONE));
    end else begin
      fb_image[idx] = d;
      p = idx * 2;
      x0 = p % DISPLAY_WIDTH;
      y0 = p / DISPLAY_WIDTH;
      x1 = x0 + 1;
      y1 = y0;
      if (x1 >= DISPLAY_WIDTH) begin
        x1 = 0;
        y1 = y0 + 1;
      end
      pending_results.push_back(pixel_result(d[31:16], x0, y0));
      pending_results.push_back(pixel_result(d[15:0], x1, y1));
      r = blank_result(KIND_DONE);
      r.changed = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // One command transfer; start stays high afterwards until the next gap or wait_all_results.
  task automatic issue_access(logic m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    address <= a;
    write_data <= d;
    do @(posedge clk); while (busy !== 1'b0);
    predict_access(m, a, d);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    fb_result_t e;
    if (!rst && strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d", kind);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        check_field("kind", DATA_W'(e.kind), DATA_W'(kind));
        check_field("read_data", e.read_data, read_data);
        check_field("pixel_x", DATA_W'(e.px), DATA_W'(pixel_x));
        check_field("pixel_y", DATA_W'(e.py), DATA_W'(pixel_y));
        check_field("red", DATA_W'(e.red), DATA_W'(red));
        check_field("green", DATA_W'(e.green), DATA_W'(green));
        check_field("blue", DATA_W'(e.blue), DATA_W'(blue));
        check_field("changed", DATA_W'(e.changed), DATA_W'(changed));
        check_field("last", DATA_W'(e.last), DATA_W'(last));
      end
    end
  end

  // Watchdog: no command or result transfer for too long.
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_cleared_frame();
    issue_access(MODE_READ, 20'h00000, 32'h0);
    issue_access(MODE_READ, 20'h4AFFC, 32'h0);
    issue_access(MODE_READ, 20'h4B000, 32'hFFFFFFFF);
    issue_access(MODE_READ, 20'hFFFFF, 32'h0);
  endtask

  task automatic test_directed_writes();
    issue_access(MODE_WRITE, 20'h00000, 32'hFFFFFFFF);
    issue_access(MODE_WRITE, 20'h00000, 32'hFFFFFFFF);
    issue_access(MODE_READ, 20'h00002, 32'h0);
    issue_access(MODE_WRITE, 20'h4AFFF, 32'hF800_07E0);
    issue_access(MODE_READ, 20'h4AFFC, 32'h0);
    issue_access(MODE_WRITE, 20'h4B000, 32'h1234_5678);
    issue_access(MODE_WRITE, 20'hFFFFF, 32'hFFFFFFFF);
    issue_access(MODE_READ, 20'hFFFFC, 32'h0);
    // end of row 0, then start of row 1
    issue_access(MODE_WRITE, 20'd956, 32'h001F_FFFF);
    issue_access(MODE_WRITE, 20'd960, 32'h1234_5678);
    issue_access(MODE_READ, 20'd961, 32'h0);
    issue_access(MODE_WRITE, 20'h00001, 32'h0000_0000);
    issue_access(MODE_WRITE, 20'h00004, 32'h0000_0000);
    issue_access(MODE_READ, 20'h00000, 32'h0);
    issue_access(MODE_WRITE, 20'h4AFFC, 32'h5555_AAAA);
    issue_access(MODE_READ, 20'h4AFFD, 32'h0);
  endtask

  task automatic test_random_traffic(int count, int pct);
    int unsigned hot [16];
    int unsigned idx;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic m;
    gap_pct = pct;
    foreach (hot[i]) hot[i] = $urandom_range(0, FB_WORDS - 1);
    hot[0] = 0;
    hot[1] = FB_WORDS - 1;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: idx = hot[$urandom_range(0, 15)];
        4, 5:       idx = $urandom_range(0, FB_WORDS - 1);
        6:          idx = FB_WORDS - 2 + $urandom_range(0, 3);
        default:    idx = $urandom_range(0, (1 << IDX_W) - 1);
      endcase
      a = {idx[IDX_W-1:0], 2'($urandom_range(0, 3))};
      m = ($urandom_range(0, 1) == 1) ? MODE_WRITE : MODE_READ;
      case ($urandom_range(0, 9))
        0, 1:    d = stored_word(idx);
        2:       d = ($urandom_range(0, 1) == 1) ? 32'hFFFFFFFF : 32'h0;
        default: d = $urandom;
      endcase
      issue_access(m, a, d);
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_READ;
    address <= '0;
    write_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_cleared_frame();
    test_directed_writes();
    wait_all_results();
    test_random_traffic(130, 32);
    wait_all_results();
    test_random_traffic(130, 70);
    wait_all_results();
    test_random_traffic(140, 0);
    wait_all_results();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: rgb565_framebuffer_with_pixel_updates_top.f
+incdir+sv
sv/rgbfb_pkg.sv
sv/rgb565_framebuffer_with_pixel_updates_top.sv
bench/testbench.sv
